[rtl/debounced_key_press_detector_core_macros.svh]
// assertion macros for the debounced key press detector
`ifndef DEBOUNCED_KEY_PRESS_DETECTOR_CORE_MACROS_SVH
`define DEBOUNCED_KEY_PRESS_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define DKP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DKP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/dkp_pkg.sv]
// shared types and constants of the debounced key press detector
package dkp_pkg;

   localparam int PIN_WIDTH        = 4;
   localparam int NUM_KEYS_DEFAULT = 4;
   localparam int COUNT_WIDTH      = 16;
   localparam int NUM_SLOTS        = 2 * PIN_WIDTH;
   localparam int SLOT_WIDTH       = $clog2(NUM_SLOTS);
   localparam int KEY_WIDTH        = $clog2(PIN_WIDTH);
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic OP_PIN_CHANGE = 1'b0;
   localparam logic OP_TICK       = 1'b1;

   localparam logic [PIN_WIDTH-1:0]   KEY_ENABLE_RESET = 4'hf;
   localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET   = 16'd3;
   localparam logic [COUNT_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef enum logic [1:0] {
      EV_PRESSED        = 2'd0,
      EV_SHORT_RELEASED = 2'd1,
      EV_LONG_PRESSED   = 2'd2,
      EV_LONG_RELEASED  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      PH_RELEASED     = 2'd0,
      PH_PRESSED      = 2'd1,
      PH_LONG_PRESSED = 2'd2
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_ENABLE       = 2'd0,
      CSR_DEBOUNCE_TICKS   = 2'd1,
      CSR_LONG_PRESS_TICKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 op;
      logic [PIN_WIDTH-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key_index;
      logic [1:0]           event_code;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [PIN_WIDTH-1:0]   key_enable_mask;
      logic [COUNT_WIDTH-1:0] debounce_ticks;
      logic [COUNT_WIDTH-1:0] long_press_ticks;
   } csr_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]      valid;
      logic [NUM_SLOTS-1:0][1:0] code;
   } batch_type;

endpackage

[rtl/dkp_eval.sv]
// key state registers and the per-item evaluation of debounce and long press
module dkp_eval #(
   parameter int NUM_KEYS = dkp_pkg::NUM_KEYS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dkp_pkg::req_type   item,
   input  dkp_pkg::csr_type   csr,
   output dkp_pkg::batch_type batch
);

   localparam int ACTIVE_KEYS = (NUM_KEYS < dkp_pkg::PIN_WIDTH) ? NUM_KEYS : dkp_pkg::PIN_WIDTH;

   logic [dkp_pkg::PIN_WIDTH-1:0]   key_exists;
   logic [dkp_pkg::PIN_WIDTH-1:0]   eff_mask;
   logic [dkp_pkg::PIN_WIDTH-1:0]   pins_masked;
   logic                            is_tick;
   logic                            deb_expire;
   logic                            deb_fire;

   logic [dkp_pkg::PIN_WIDTH-1:0]   snapshot_ff, snapshot_in;
   logic [dkp_pkg::COUNT_WIDTH-1:0] deb_count_ff, deb_count_in;
   logic                            deb_run_ff, deb_run_in;

   logic                            hold_ev   [dkp_pkg::PIN_WIDTH];
   logic                            deb_ev    [dkp_pkg::PIN_WIDTH];
   dkp_pkg::event_type              deb_code  [dkp_pkg::PIN_WIDTH];

   genvar k;

   for (k = 0; k < dkp_pkg::PIN_WIDTH; k++) begin : g_exists
      assign key_exists[k] = (k < ACTIVE_KEYS);
   end

   assign eff_mask    = csr.key_enable_mask & key_exists;
   assign pins_masked = item.pin_levels & eff_mask;
   assign is_tick     = (item.op == dkp_pkg::OP_TICK);
   assign deb_expire  = is_tick && deb_run_ff && (deb_count_ff <= dkp_pkg::COUNT_WIDTH'(1));
   assign deb_fire    = deb_expire && (pins_masked == snapshot_ff);

   always_comb begin
      snapshot_in  = snapshot_ff;
      deb_count_in = deb_count_ff;
      deb_run_in   = deb_run_ff;
      if (!is_tick) begin
         snapshot_in  = pins_masked;
         deb_count_in = csr.debounce_ticks;
         deb_run_in   = 1'b1;
      end else if (deb_expire) begin
         deb_count_in = '0;
         deb_run_in   = 1'b0;
      end else if (deb_run_ff) begin
         deb_count_in = deb_count_ff - dkp_pkg::COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snapshot_ff  <= key_exists;
         deb_count_ff <= '0;
         deb_run_ff   <= 1'b0;
      end else if (load) begin
         snapshot_ff  <= snapshot_in;
         deb_count_ff <= deb_count_in;
         deb_run_ff   <= deb_run_in;
      end
   end

   for (k = 0; k < dkp_pkg::PIN_WIDTH; k++) begin : g_key
      if (k < ACTIVE_KEYS) begin : g_live
         dkp_pkg::phase_type              phase_ff, phase_in, phase_mid;
         logic [dkp_pkg::COUNT_WIDTH-1:0] hold_cnt_ff, hold_cnt_in, hold_cnt_mid;
         logic                            hold_run_ff, hold_run_in, hold_run_mid;
         logic                            pressed;
         logic                            hold_expire;
         logic                            key_ev;
         dkp_pkg::event_type              key_code;

         assign pressed     = eff_mask[k] && !item.pin_levels[k];
         assign hold_expire = is_tick && hold_run_ff
                              && (hold_cnt_ff <= dkp_pkg::COUNT_WIDTH'(1));
         assign hold_ev[k]  = hold_expire && (phase_ff == dkp_pkg::PH_PRESSED);
         assign deb_ev[k]   = key_ev;
         assign deb_code[k] = key_code;

         always_comb begin
            phase_mid    = phase_ff;
            hold_cnt_mid = hold_cnt_ff;
            hold_run_mid = hold_run_ff;
            if (hold_expire) begin
               hold_cnt_mid = '0;
               hold_run_mid = 1'b0;
               if (phase_ff == dkp_pkg::PH_PRESSED) begin
                  phase_mid = dkp_pkg::PH_LONG_PRESSED;
               end
            end else if (is_tick && hold_run_ff) begin
               hold_cnt_mid = hold_cnt_ff - dkp_pkg::COUNT_WIDTH'(1);
            end

            phase_in    = phase_mid;
            hold_cnt_in = hold_cnt_mid;
            hold_run_in = hold_run_mid;
            key_ev      = 1'b0;
            key_code    = dkp_pkg::EV_PRESSED;
            if (deb_fire) begin
               case (phase_mid)
                  dkp_pkg::PH_PRESSED: begin
                     if (!pressed) begin
                        phase_in    = dkp_pkg::PH_RELEASED;
                        hold_cnt_in = '0;
                        hold_run_in = 1'b0;
                        key_ev      = 1'b1;
                        key_code    = dkp_pkg::EV_SHORT_RELEASED;
                     end
                  end
                  dkp_pkg::PH_LONG_PRESSED: begin
                     if (!pressed) begin
                        phase_in    = dkp_pkg::PH_RELEASED;
                        hold_cnt_in = '0;
                        hold_run_in = 1'b0;
                        key_ev      = 1'b1;
                        key_code    = dkp_pkg::EV_LONG_RELEASED;
                     end
                  end
                  default: begin
                     if (pressed) begin
                        phase_in    = dkp_pkg::PH_PRESSED;
                        hold_cnt_in = csr.long_press_ticks;
                        hold_run_in = 1'b1;
                        key_ev      = 1'b1;
                        key_code    = dkp_pkg::EV_PRESSED;
                     end
                  end
               endcase
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff    <= dkp_pkg::PH_RELEASED;
               hold_cnt_ff <= '0;
               hold_run_ff <= 1'b0;
            end else if (load) begin
               phase_ff    <= phase_in;
               hold_cnt_ff <= hold_cnt_in;
               hold_run_ff <= hold_run_in;
            end
         end
      end else begin : g_absent
         assign hold_ev[k]  = 1'b0;
         assign deb_ev[k]   = 1'b0;
         assign deb_code[k] = dkp_pkg::EV_PRESSED;
      end
   end

   // long-press slots first, then debounce slots, each in key order
   always_comb begin
      batch = '0;
      for (int i = 0; i < dkp_pkg::PIN_WIDTH; i++) begin
         batch.valid[i]                      = hold_ev[i];
         batch.code[i]                       = dkp_pkg::EV_LONG_PRESSED;
         batch.valid[i + dkp_pkg::PIN_WIDTH] = deb_ev[i];
         batch.code[i + dkp_pkg::PIN_WIDTH]  = deb_code[i];
      end
   end

endmodule

[rtl/dkp_evq.sv]
// result register holding one item's events and handing them out one per cycle while rsp_ready is high
module dkp_evq (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dkp_pkg::batch_type batch,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dkp_pkg::rsp_type   rsp_data
);

   logic [dkp_pkg::NUM_SLOTS-1:0]      pend_ff, pend_in;
   logic [dkp_pkg::NUM_SLOTS-1:0][1:0] code_ff;
   logic [dkp_pkg::SLOT_WIDTH-1:0]     sel;
   logic [dkp_pkg::NUM_SLOTS-1:0]      rest;

   always_comb begin
      sel = '0;
      for (int i = dkp_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = dkp_pkg::SLOT_WIDTH'(i);
         end
      end
   end

   assign rest      = pend_ff & ~(dkp_pkg::NUM_SLOTS'(1) << sel);
   assign rsp_valid = |pend_ff;
   assign free      = !rsp_valid || (rsp_ready && (rest == '0));

   assign rsp_data.key_index  = sel[dkp_pkg::KEY_WIDTH-1:0];
   assign rsp_data.event_code = code_ff[sel];
   assign rsp_data.last       = (rest == '0);

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = batch.valid;
      end else if (rsp_valid && rsp_ready) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= batch.code;
      end
   end

endmodule

[rtl/debounced_key_press_detector_core.sv]
// top level of the debounced key press detector with long-press events
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     dkp_pkg::req_type (op, pin_levels)
//   rsp      out        rsp_valid / rsp_ready     dkp_pkg::rsp_type (key_index, event_code, last)
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// an item is registered, evaluated combinationally, and its events (up to eight) are
// loaded into the result register; the first event is offered the cycle after that load
// items without events are taken every cycle; an item with k events holds the result
// port until all k are taken, one event per cycle while rsp_ready is high, while one more item
// waits in the input register and req_ready stays low until the last event is taken
// csr writes are always taken; reset is synchronous
module debounced_key_press_detector_core #(
   parameter int NUM_KEYS = dkp_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  dkp_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output dkp_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dkp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dkp_pkg::COUNT_WIDTH-1:0]       csr_data
);

   dkp_pkg::csr_type   csr_ff;
   dkp_pkg::req_type   in_ff;
   logic               in_valid_ff, in_valid_in;
   logic               free;
   logic               load;
   dkp_pkg::batch_type batch;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.key_enable_mask  <= dkp_pkg::KEY_ENABLE_RESET;
         csr_ff.debounce_ticks   <= dkp_pkg::DEBOUNCE_RESET;
         csr_ff.long_press_ticks <= dkp_pkg::LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dkp_pkg::CSR_KEY_ENABLE:
               csr_ff.key_enable_mask <= csr_data[dkp_pkg::PIN_WIDTH-1:0];
            dkp_pkg::CSR_DEBOUNCE_TICKS:
               csr_ff.debounce_ticks <= csr_data;
            dkp_pkg::CSR_LONG_PRESS_TICKS:
               csr_ff.long_press_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   assign load      = in_valid_ff && free;
   assign req_ready = !in_valid_ff || free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   dkp_eval #(
      .NUM_KEYS (NUM_KEYS)
   ) u_eval (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .item  (in_ff),
      .csr   (csr_ff),
      .batch (batch)
   );

   dkp_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .batch     (batch),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/dkp_checker.sv]
// port-level checks for the debounced key press detector, bound to the top level
`include "debounced_key_press_detector_core_macros.svh"

module dkp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dkp_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);

   `DKP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   `DKP_ASSERT_NEXT(a_burst_continues, clock, reset, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid, "events of one item not back to back")

   `DKP_ASSERT_IMP(a_csr_always_ready, clock, reset, csr_valid, csr_ready, "csr write not taken")

   `DKP_ASSERT_IMP(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind debounced_key_press_detector_core dkp_checker u_dkp_checker (.*);
